[design/adcma_pkg.sv]
// Shared types and constants for the converter moving-average and stability block.
// Holds field widths, action and status codes, register indexes and the state type.
// No dependencies; every other design file imports this package.
`default_nettype none

package adcma_pkg;

   // Field widths of the transactions.
   localparam int LEVEL_W     = 10;
   localparam int CNT_W       = 4;
   localparam int CH_W        = 4;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   // Reset values.
   localparam logic [LEVEL_W-1:0] START_LEVEL    = 10'd500;
   localparam logic [LEVEL_W-1:0] THRESH_RESET   = 10'd10;
   localparam logic [CNT_W-1:0]   DEBOUNCE_RESET = 4'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 1'b1;

   // Channel status codes.
   localparam logic [STATUS_W-1:0] STATUS_STABLE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNSTABLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_SAMPLE    = 2'd0,
      ACT_CONDITION = 2'd1,
      ACT_MONITOR   = 2'd2,
      ACT_READ      = 2'd3
   } action_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SMP_RD,
      ST_SMP_WR,
      ST_CND_RD,
      ST_CND_WIN,
      ST_CND_SUM,
      ST_CND_DIV,
      ST_MON_RD,
      ST_MON_WR,
      ST_REP_RD,
      ST_REP
   } state_type;

endpackage

`default_nettype wire

[design/adcma_div.sv]
// Window mean unit: floored division of a window sum by a constant depth.
// Uses a scaled reciprocal multiplication on a registered operand; uses adcma_pkg.
`default_nettype none

module adcma_div
   import adcma_pkg::*;
#(
   parameter int DIVIDEND_W = 13,
   parameter int DIVISOR    = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   output logic                       done,
   output logic      [LEVEL_W-1:0]    quotient
);

   // The reciprocal is rounded up and scaled by one more bit than the divisor
   // needs, which keeps the floored product exact over the whole dividend range.
   localparam int     SHIFT     = DIVIDEND_W + $clog2(DIVISOR);
   localparam int     RECIP_W   = DIVIDEND_W + 1;
   localparam int     PROD_W    = DIVIDEND_W + RECIP_W;
   localparam longint RECIP_VAL =
      ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic [DIVIDEND_W-1:0] dividend_ff;
   logic                  done_ff;
   logic [PROD_W-1:0]     product;

   // The result is ready in the cycle after start.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Operand register.
   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
      end
   end

   // Multiply by the reciprocal and keep the integer part.
   assign product  = PROD_W'(dividend_ff) * PROD_W'(RECIP);
   assign done     = done_ff;
   assign quotient = product[SHIFT +: LEVEL_W];

endmodule

`default_nettype wire

[design/adcma_win_mem.sv]
// Window sample memory: one write port and one read port, registered read data.
// Holds every channel's ring window back to back; uses adcma_pkg.
`default_nettype none

module adcma_win_mem
   import adcma_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [LEVEL_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [LEVEL_W-1:0] rd_data
);

   logic [LEVEL_W-1:0] mem [DEPTH];
   logic [LEVEL_W-1:0] rd_data_ff;

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/adc_moving_average_stability.sv]
// Multichannel converter conditioner: windowed mean per channel with stability debounce.
// Uses adcma_pkg, adcma_win_mem (window samples) and adcma_div (mean unit).
//
// Usage:
//   req channel: one transaction per action. req_tuser carries the action (sample,
//   condition tick, monitor tick, read); req_tdata carries channel and sample.
//   rsp channel: exactly one transaction per request, reporting the request's channel
//   after the action has taken effect (status 2 and zeros for a nonexistent channel).
//   csr channel: writes the threshold (index 0) and the debounce limit (index 1);
//   always ready, to be written while no request is in flight.
// Steps: a read or an invalid sample reads the channel state and loads the response;
//   a sample first reads and writes back the channel record; a monitor tick reads and
//   writes back each of the N channels in turn; a condition tick runs four steps per
//   channel: the state read, the window read, the running-sum update and the registered mean.
//   One request is worked on at a time; the next is taken once the response is in the
//   output register, even while the receiver stalls it.
// Reset: the block runs a clearing pass over all NUM_CHANNELS * WINDOW_DEPTH window slots
//   that fills window and channel state with their start values; req_tready stays low
//   until it ends. A stalled response holds in the output register and blocks only the
//   completion of the following request.
`default_nettype none

module adc_moving_average_stability
   import adcma_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int WINDOW_DEPTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request: tdata = channel[3:0], sample[13:4], zero [15:14]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // Request: tuser = action[1:0]
   input  wire logic [1:0]             req_tuser,
   // Response: tdata = channel_average[9:0], channel_status[11:10],
   //           settled_value[21:12], zero [23:22]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int POS_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W     = LEVEL_W + $clog2(WINDOW_DEPTH);
   localparam int CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int WIN_DEPTH = NUM_CHANNELS * WINDOW_DEPTH;
   localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(500 * WINDOW_DEPTH);
   localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WIN_DEPTH - 1);
   localparam logic [CH_AW-1:0]  CH_LAST   = CH_AW'(NUM_CHANNELS - 1);
   localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW_DEPTH - 1);

   // Per-channel state record held in the channel memory.
   typedef struct packed {
      logic [LEVEL_W-1:0] latest;
      logic [POS_W-1:0]   pos;
      logic [SUM_W-1:0]   sum;
      logic [LEVEL_W-1:0] mean;
      logic [LEVEL_W-1:0] ref_lvl;
      logic [CNT_W-1:0]   quiet;
      logic               unstable;
      logic [LEVEL_W-1:0] latched;
   } chan_rec_type;

   localparam chan_rec_type CHAN_RESET = '{
      latest:   START_LEVEL,
      pos:      '0,
      sum:      SUM_RESET,
      mean:     START_LEVEL,
      ref_lvl:  START_LEVEL,
      quiet:    '0,
      unstable: 1'b0,
      latched:  '0
   };

   // Registers.
   state_type           state_ff, state_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [LEVEL_W-1:0]  smp_ff, smp_in;
   logic [CH_AW-1:0]    cidx_ff, cidx_in;
   logic [WIN_AW-1:0]   base_ff, base_in;
   logic [WIN_AW-1:0]   clr_ff, clr_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [LEVEL_W-1:0]  thresh_ff;
   logic [CNT_W-1:0]    debounce_ff;

   // Channel memory ports.
   chan_rec_type        chan_ram [NUM_CHANNELS];
   chan_rec_type        chan_rd_ff;
   logic                chan_re, chan_we;
   logic [CH_AW-1:0]    chan_raddr, chan_waddr;
   chan_rec_type        chan_wdata;

   // Window memory ports.
   logic                win_we, win_re;
   logic [WIN_AW-1:0]   win_waddr, win_raddr;
   logic [LEVEL_W-1:0]  win_wdata, win_rd_data;
   logic [WIN_AW-1:0]   win_slot;

   // Mean unit.
   logic                div_start, div_done;
   logic [LEVEL_W-1:0]  div_quo;

   // Decoded request fields and helpers.
   logic [CH_W-1:0]     req_channel;
   logic [LEVEL_W-1:0]  req_sample;
   action_type          req_action;
   logic                req_ch_ok, ch_ok;
   logic [POS_W-1:0]    pos_next;
   chan_rec_type        mon_rec;
   logic [LEVEL_W-1:0]  mon_diff;
   logic [CNT_W:0]      mon_next;
   logic [STATUS_W-1:0] rep_status;

   assign req_channel = req_tdata[CH_W-1:0];
   assign req_sample  = req_tdata[CH_W +: LEVEL_W];
   assign req_action  = action_type'(req_tuser);
   assign req_ch_ok   = ({1'b0, req_channel} < (CH_W+1)'(NUM_CHANNELS));
   assign ch_ok       = ({1'b0, ch_ff} < (CH_W+1)'(NUM_CHANNELS));
   assign win_slot    = base_ff + WIN_AW'(chan_rd_ff.pos);
   assign pos_next    = (chan_rd_ff.pos == POS_LAST) ? '0 : chan_rd_ff.pos + POS_W'(1);

   // Monitor update of one channel record.
   always_comb begin
      mon_rec  = chan_rd_ff;
      mon_diff = (chan_rd_ff.mean >= chan_rd_ff.ref_lvl) ?
                 chan_rd_ff.mean - chan_rd_ff.ref_lvl : chan_rd_ff.ref_lvl - chan_rd_ff.mean;
      mon_next = {1'b0, chan_rd_ff.quiet} + (CNT_W+1)'(1);
      if (mon_diff < thresh_ff) begin
         if (mon_next > {1'b0, debounce_ff}) begin
            mon_rec.quiet    = '0;
            mon_rec.unstable = 1'b0;
            mon_rec.latched  = chan_rd_ff.mean;
         end else begin
            mon_rec.quiet = mon_next[CNT_W-1:0];
         end
      end else begin
         mon_rec.quiet    = '0;
         mon_rec.ref_lvl  = chan_rd_ff.mean;
         mon_rec.unstable = 1'b1;
      end
   end

   assign rep_status = chan_rd_ff.unstable ? STATUS_UNSTABLE : STATUS_STABLE;

   // Sequencer: next state, memory controls and response loading.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      cidx_in      = cidx_ff;
      base_in      = base_ff;
      clr_in       = clr_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      chan_re      = 1'b0;
      chan_raddr   = ch_ff[CH_AW-1:0];
      chan_we      = 1'b0;
      chan_waddr   = cidx_ff;
      chan_wdata   = chan_rd_ff;
      win_we       = 1'b0;
      win_waddr    = win_slot;
      win_wdata    = chan_rd_ff.latest;
      win_re       = 1'b0;
      win_raddr    = win_slot;
      div_start    = 1'b0;
      req_tready   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            win_we    = 1'b1;
            win_waddr = clr_ff;
            win_wdata = START_LEVEL;
            if ({1'b0, clr_ff} < (WIN_AW+1)'(NUM_CHANNELS)) begin
               chan_we    = 1'b1;
               chan_waddr = clr_ff[CH_AW-1:0];
               chan_wdata = CHAN_RESET;
            end
            clr_in = clr_ff + WIN_AW'(1);
            if (clr_ff == WIN_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ch_in   = req_channel;
               smp_in  = req_sample;
               cidx_in = '0;
               base_in = '0;
               case (req_action)
                  ACT_SAMPLE:    state_in = req_ch_ok ? ST_SMP_RD : ST_REP_RD;
                  ACT_CONDITION: state_in = ST_CND_RD;
                  ACT_MONITOR:   state_in = ST_MON_RD;
                  default:       state_in = ST_REP_RD;
               endcase
            end
         end
         // Sample: replace the channel's latest raw reading.
         ST_SMP_RD: begin
            chan_re  = 1'b1;
            state_in = ST_SMP_WR;
         end
         ST_SMP_WR: begin
            chan_we           = 1'b1;
            chan_waddr        = ch_ff[CH_AW-1:0];
            chan_wdata.latest = smp_ff;
            state_in          = ST_REP_RD;
         end
         // Condition tick: push the raw reading, update the running sum, divide.
         ST_CND_RD: begin
            chan_re    = 1'b1;
            chan_raddr = cidx_ff;
            state_in   = ST_CND_WIN;
         end
         ST_CND_WIN: begin
            win_re   = 1'b1;
            state_in = ST_CND_SUM;
         end
         ST_CND_SUM: begin
            win_we    = 1'b1;
            sum_in    = chan_rd_ff.sum - SUM_W'(win_rd_data) + SUM_W'(chan_rd_ff.latest);
            div_start = 1'b1;
            state_in  = ST_CND_DIV;
         end
         ST_CND_DIV: begin
            if (div_done) begin
               chan_we         = 1'b1;
               chan_wdata.mean = div_quo;
               chan_wdata.sum  = sum_ff;
               chan_wdata.pos  = pos_next;
               if (cidx_ff == CH_LAST) begin
                  state_in = ST_REP_RD;
               end else begin
                  cidx_in  = cidx_ff + CH_AW'(1);
                  base_in  = base_ff + WIN_AW'(WINDOW_DEPTH);
                  state_in = ST_CND_RD;
               end
            end
         end
         // Monitor tick: debounce each channel in turn.
         ST_MON_RD: begin
            chan_re    = 1'b1;
            chan_raddr = cidx_ff;
            state_in   = ST_MON_WR;
         end
         ST_MON_WR: begin
            chan_we    = 1'b1;
            chan_wdata = mon_rec;
            if (cidx_ff == CH_LAST) begin
               state_in = ST_REP_RD;
            end else begin
               cidx_in  = cidx_ff + CH_AW'(1);
               state_in = ST_MON_RD;
            end
         end
         // Report the requested channel once the output register is free.
         ST_REP_RD: begin
            chan_re  = 1'b1;
            state_in = ST_REP;
         end
         ST_REP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (ch_ok) begin
                  rsp_data_in = {2'b00, chan_rd_ff.latched, rep_status, chan_rd_ff.mean};
               end else begin
                  rsp_data_in = {2'b00, {LEVEL_W{1'b0}}, STATUS_INVALID, {LEVEL_W{1'b0}}};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      smp_ff      <= smp_in;
      cidx_ff     <= cidx_in;
      base_ff     <= base_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= THRESH_RESET;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: thresh_ff   <= csr_data;
            CSR_DEBOUNCE:  debounce_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Channel state memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_ram[chan_waddr] <= chan_wdata;
      end
      if (chan_re) begin
         chan_rd_ff <= chan_ram[chan_raddr];
      end
   end

   adcma_win_mem #(
      .DEPTH (WIN_DEPTH),
      .AW    (WIN_AW)
   ) u_win_mem (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_waddr),
      .wr_data (win_wdata),
      .rd_en   (win_re),
      .rd_addr (win_raddr),
      .rd_data (win_rd_data)
   );

   adcma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR    (WINDOW_DEPTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // No request is taken while the clearing pass runs.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // The mean unit only finishes while the sequencer waits for it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_CND_DIV))
      else $error("divider result with no condition tick waiting");

   // A written quiet count never exceeds the debounce limit.
   a_quiet_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MON_WR) |-> (chan_wdata.quiet <= debounce_ff))
      else $error("quiet count above debounce limit");

   // A response only appears after the report state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_REP))
      else $error("response raised outside report state");

endmodule

`default_nettype wire
